// ----- src/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and codes of the frame slot ownership pool
// Word layouts of both channels, request and status codes, slot modes,
// controller states and the command/status groups between the two halves.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // default pool depth
    localparam int MAX_SLOTS_DEF = 16;

    // request codes
    localparam logic [2:0] FUNC_REGISTER   = 3'd0;
    localparam logic [2:0] FUNC_UNREGISTER = 3'd1;
    localparam logic [2:0] FUNC_SUBMIT     = 3'd2;
    localparam logic [2:0] FUNC_TAKE       = 3'd3;
    localparam logic [2:0] FUNC_RELEASE    = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_NOT_HELD = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [1:0] CFG_RANGE_END  = 2'd1;
    localparam logic [1:0] CFG_LOOP       = 2'd2;

    // configuration reset values
    localparam logic [4:0]  SLOT_COUNT_RST = 5'd16;
    localparam logic [63:0] RANGE_END_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_UNBOUND = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_FILLED  = 2'd2,
        MODE_HELD    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         slot_index;
        logic [63:0]        sequence_req;
        logic signed [63:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_slot;
        logic [63:0] out_sequence;
        logic        wrapped;
        logic        dropped;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic scan_clear;
        logic scan_read;
        logic apply;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic n_zero;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- src/fsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsp_ctrl: request sequencer of the frame slot ownership pool
// Takes a request word, runs the slot scan when the request needs one and
// commits the result once the output register can take it.
// ----------------------------------------------------------------------------
module fsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fsp_pkg::t_dp_status i_sts,
    output fsp_pkg::t_ctrl_cmd  o_cmd
);

    fsp_pkg::t_state r_state;
    fsp_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fsp_pkg::S_DECODE;
                end
            end
            fsp_pkg::S_DECODE: begin
                if (i_sts.needs_scan && !i_sts.n_zero) begin
                    n_state = fsp_pkg::S_SCAN;
                end else begin
                    n_state = fsp_pkg::S_APPLY;
                end
            end
            fsp_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = fsp_pkg::S_DRAIN;
                end
            end
            fsp_pkg::S_DRAIN: begin
                n_state = fsp_pkg::S_APPLY;
            end
            fsp_pkg::S_APPLY: begin
                if (i_sts.out_free) begin
                    n_state = fsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsp_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            fsp_pkg::S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.load_req = i_in_valid;
            end
            fsp_pkg::S_DECODE: begin
                o_cmd.scan_clear = 1'b1;
            end
            fsp_pkg::S_SCAN: begin
                o_cmd.scan_read = 1'b1;
            end
            fsp_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            fsp_pkg::S_APPLY: begin
                o_cmd.apply = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // a scan never starts on an empty pool
    a_scan_needs_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsp_pkg::S_SCAN) |-> !i_sts.n_zero)
        else $error("scan running with zero active slots");

    // a committed result ends the request
    a_apply_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> (r_state == fsp_pkg::S_IDLE))
        else $error("request not finished after commit");

    // a request word is taken only while nothing is in flight
    a_load_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |=> (r_state == fsp_pkg::S_DECODE))
        else $error("request word loaded outside idle");

endmodule

// ----- src/fsp_dpath.sv -----
// ----------------------------------------------------------------------------
// fsp_dpath: slot storage and decision logic of the frame slot ownership pool
// Holds configuration, slot modes, sequence and time memories, the scan
// pipeline that finds the target slot, and the output register.
// ----------------------------------------------------------------------------
module fsp_dpath #(
    parameter int MAX_SLOTS = fsp_pkg::MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsp_pkg::t_ctrl_cmd  i_cmd,
    output fsp_pkg::t_dp_status o_sts,
    input  fsp_pkg::t_in_word   i_in_data,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output logic                o_out_valid,
    output fsp_pkg::t_out_word  o_out_data,
    input  logic                i_out_stall
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = ($clog2(MAX_SLOTS + 1) > 5) ? $clog2(MAX_SLOTS + 1) : 5;

    // configuration
    logic [4:0]  r_slot_count;
    logic [63:0] r_range_end;
    logic        r_loop;

    // request and slot state
    fsp_pkg::t_in_word r_req;
    fsp_pkg::t_mode    r_mode [MAX_SLOTS];
    logic [63:0]       r_mem_seq [MAX_SLOTS];
    logic [63:0]       r_mem_time [MAX_SLOTS];
    logic [63:0]       r_last_submitted;

    // scan pipeline
    logic [IW-1:0]  r_scan;
    logic           r_pv;
    logic [IW-1:0]  r_pidx;
    fsp_pkg::t_mode r_pmode;
    logic [63:0]    r_rd_seq;
    logic [63:0]    r_rd_time;
    logic           r_found;
    logic [IW-1:0]  r_best;
    logic [63:0]    r_best_seq;
    logic [63:0]    r_best_time;
    logic           w_hit;

    // output register
    logic               r_out_valid;
    fsp_pkg::t_out_word r_out_data;

    // commit logic
    logic [CW-1:0]      w_count_ext;
    logic [CW-1:0]      w_active;
    logic [CW-1:0]      w_idx_ext;
    logic [CW-1:0]      w_best_ext;
    logic               w_idx_ok;
    logic [IW-1:0]      w_idx;
    fsp_pkg::t_mode     w_idx_mode;
    logic               w_has_end;
    logic               w_t_gt;
    logic               w_t_eq;
    fsp_pkg::t_out_word w_res;
    logic               w_mode_we;
    logic [IW-1:0]      w_mode_addr;
    fsp_pkg::t_mode     w_mode_val;
    logic               w_submit_we;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= fsp_pkg::SLOT_COUNT_RST;
            r_range_end  <= fsp_pkg::RANGE_END_NONE;
            r_loop       <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fsp_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[4:0];
                fsp_pkg::CFG_RANGE_END:  r_range_end  <= i_cfg_data;
                fsp_pkg::CFG_LOOP:       r_loop       <= i_cfg_data[0];
                default:                 r_loop       <= r_loop;
            endcase
        end
    end

    // active slot count and addressed slot
    assign w_count_ext = CW'(r_slot_count);
    assign w_active    = (w_count_ext >= CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : w_count_ext;
    assign w_idx_ext   = CW'(r_req.slot_index);
    assign w_idx_ok    = w_idx_ext < w_active;
    assign w_idx       = w_idx_ext[IW-1:0];
    assign w_idx_mode  = r_mode[w_idx];
    assign w_best_ext  = CW'(r_best);

    // request word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_data;
        end
    end

    // slot modes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_mode[i] <= fsp_pkg::MODE_UNBOUND;
            end
        end else if (i_cmd.apply && w_mode_we) begin
            r_mode[w_mode_addr] <= w_mode_val;
        end
    end

    // sequence and time memories, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && w_submit_we) begin
            r_mem_seq[w_idx]  <= r_req.sequence_req;
            r_mem_time[w_idx] <= r_req.timestamp;
        end
        if (i_cmd.scan_read) begin
            r_rd_seq  <= r_mem_seq[r_scan];
            r_rd_time <= r_mem_time[r_scan];
        end
    end

    // last accepted sequence number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_submitted <= '0;
        end else if (i_cmd.apply && w_submit_we) begin
            r_last_submitted <= r_req.sequence_req;
        end
    end

    // scan match for the current slot
    always_comb begin
        w_hit = 1'b0;
        if (r_pv) begin
            case (r_req.func)
                fsp_pkg::FUNC_REGISTER: begin
                    w_hit = (r_pmode == fsp_pkg::MODE_UNBOUND) && !r_found;
                end
                fsp_pkg::FUNC_TAKE: begin
                    w_hit = (r_pmode == fsp_pkg::MODE_FILLED) &&
                            (!r_found || (r_rd_seq < r_best_seq));
                end
                fsp_pkg::FUNC_RELEASE: begin
                    w_hit = (r_pmode == fsp_pkg::MODE_HELD) &&
                            (r_rd_seq == r_req.sequence_req) && !r_found;
                end
                default: begin
                    w_hit = 1'b0;
                end
            endcase
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_read;
            if (i_cmd.scan_clear) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_read) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (w_hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_read) begin
            r_pidx  <= r_scan;
            r_pmode <= r_mode[r_scan];
        end
        if (w_hit) begin
            r_best      <= r_pidx;
            r_best_seq  <= r_rd_seq;
            r_best_time <= r_rd_time;
        end
    end

    // range gate on the chosen frame
    assign w_has_end = r_range_end != fsp_pkg::RANGE_END_NONE;
    assign w_t_gt    = $signed(r_best_time) > $signed(r_range_end);
    assign w_t_eq    = r_best_time == r_range_end;

    // result and state update
    always_comb begin
        w_res       = '0;
        w_mode_we   = 1'b0;
        w_mode_addr = w_idx;
        w_mode_val  = fsp_pkg::MODE_IDLE;
        w_submit_we = 1'b0;
        case (r_req.func)
            fsp_pkg::FUNC_REGISTER: begin
                if (r_found) begin
                    w_mode_we      = 1'b1;
                    w_mode_addr    = r_best;
                    w_res.out_slot = w_best_ext[3:0];
                end else begin
                    w_res.status = fsp_pkg::ST_BUSY;
                end
            end
            fsp_pkg::FUNC_UNREGISTER: begin
                if (!w_idx_ok) begin
                    w_res.status = fsp_pkg::ST_UNKNOWN;
                end else if (w_idx_mode == fsp_pkg::MODE_FILLED ||
                             w_idx_mode == fsp_pkg::MODE_HELD) begin
                    w_res.status = fsp_pkg::ST_BUSY;
                end else if (w_idx_mode == fsp_pkg::MODE_UNBOUND) begin
                    w_res.status = fsp_pkg::ST_INVALID;
                end else begin
                    w_mode_we  = 1'b1;
                    w_mode_val = fsp_pkg::MODE_UNBOUND;
                end
            end
            fsp_pkg::FUNC_SUBMIT: begin
                if (!w_idx_ok || w_idx_mode == fsp_pkg::MODE_UNBOUND) begin
                    w_res.status = fsp_pkg::ST_UNKNOWN;
                end else if (w_idx_mode != fsp_pkg::MODE_IDLE) begin
                    w_res.status = fsp_pkg::ST_BUSY;
                end else if (r_req.sequence_req <= r_last_submitted) begin
                    w_res.status = fsp_pkg::ST_INVALID;
                end else begin
                    w_mode_we   = 1'b1;
                    w_mode_val  = fsp_pkg::MODE_FILLED;
                    w_submit_we = 1'b1;
                end
            end
            fsp_pkg::FUNC_TAKE: begin
                if (!r_found) begin
                    w_res.status = fsp_pkg::ST_EMPTY;
                end else if (w_has_end && w_t_gt && !r_loop) begin
                    // past the range end, frame is discarded
                    w_mode_we     = 1'b1;
                    w_mode_addr   = r_best;
                    w_res.status  = fsp_pkg::ST_EMPTY;
                    w_res.dropped = 1'b1;
                end else begin
                    w_mode_we          = 1'b1;
                    w_mode_addr        = r_best;
                    w_mode_val         = fsp_pkg::MODE_HELD;
                    w_res.out_slot     = w_best_ext[3:0];
                    w_res.out_sequence = r_best_seq;
                    w_res.wrapped      = w_has_end && (w_t_gt || w_t_eq) && r_loop;
                end
            end
            fsp_pkg::FUNC_RELEASE: begin
                if (r_found) begin
                    w_mode_we   = 1'b1;
                    w_mode_addr = r_best;
                end else begin
                    w_res.status = fsp_pkg::ST_NOT_HELD;
                end
            end
            default: begin
                w_res.status = fsp_pkg::ST_INVALID;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // status to the controller
    assign o_sts.needs_scan = (r_req.func == fsp_pkg::FUNC_REGISTER) ||
                              (r_req.func == fsp_pkg::FUNC_TAKE) ||
                              (r_req.func == fsp_pkg::FUNC_RELEASE);
    assign o_sts.n_zero     = w_active == '0;
    assign o_sts.scan_last  = CW'(r_scan) == (w_active - CW'(1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // a result never overwrites one that is still waiting
    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> (!r_out_valid || !i_out_stall))
        else $error("result committed over a waiting word");

    // accepted sequence numbers only grow
    a_last_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_last_submitted >= $past(r_last_submitted)))
        else $error("last submitted sequence went backwards");

endmodule

// ----- src/frame_slot_ownership_pool.sv -----
// ----------------------------------------------------------------------------
// frame_slot_ownership_pool: top level of the frame slot ownership pool
// Requests (register, unregister, submit, take, release) arrive as one word
// on the input channel (i_in_valid / o_in_stall) and each gives exactly one
// result word on the output channel (o_out_valid / i_out_stall). A word moves
// at a clock edge where valid is high and stall is low.
// Configuration (slot count, range end, loop enable) is written over
// i_cfg_valid / o_cfg_ready with a register index; ready is always high and
// writes are meant to happen while no request is in flight.
// Unregister and submit go from decode straight to commit, and the result
// leaves through the output register; register, take and release scan all
// N active slots through the sequence/time read port, one slot per cycle,
// then drain the read pipeline and commit (no scan with no active slot).
// A new word is taken the cycle after each commit, so requests never overlap.
// Reset clears all slots to unbound, the last sequence number to zero and
// the configuration to 16 slots, no range end and looping on; no clearing
// pass is needed. When the receiver stalls, the result waits in the output
// register; the next request word is still taken and is held just before
// its commit until the output register frees up.
// ----------------------------------------------------------------------------
module frame_slot_ownership_pool #(
    parameter int MAX_SLOTS = fsp_pkg::MAX_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fsp_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsp_pkg::t_out_word o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    fsp_pkg::t_ctrl_cmd  w_cmd;
    fsp_pkg::t_dp_status w_sts;

    // configuration writes never wait
    assign o_cfg_ready = 1'b1;

    // request sequencer
    fsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot storage and decisions
    fsp_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
